// File: rtl/filled_shape_pixel_generator_macros.svh
// Assertion macros for the fill engine checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FILLED_SHAPE_PIXEL_GENERATOR_MACROS_SVH
`define FILLED_SHAPE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication
`define FSPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fspg check failed");

// next-cycle implication
`define FSPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fspg check failed");

`endif

// File: rtl/fspg_pkg.sv
// Shared types and constants of the filled shape pixel generator.
// No dependencies.
package fspg_pkg;

    localparam int MAX_RES = 4096;
    localparam int RES_W   = $clog2(MAX_RES) + 1;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int COLOR_W = 24;
    localparam int ADDR_W  = 24;
    localparam int CFG_W   = 13;
    localparam int DIFF_W  = RES_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int PROD_W  = 2 * RES_W;

    typedef enum logic [1:0] {
        OP_RECT = 2'd0,
        OP_CIRC = 2'd1,
        OP_STEP = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_IDLE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RECT = 2'd1,
        MODE_CIRC = 2'd2
    } mode_t;

    typedef enum logic {
        CFG_H_RES = 1'b0,
        CFG_V_RES = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        status_t              status;
        logic                 draw;
        logic                 circ;
        logic                 lst;
        logic [RES_W-1:0]     row;
        logic [RES_W-1:0]     col;
        logic [POS_W-1:0]     centre_col;
        logic [POS_W-1:0]     centre_row;
        logic [ADDR_W-1:0]    radius_sq;
        logic [COLOR_W-1:0]   color;
    } pix_work_t;

endpackage

// File: rtl/fspg_ctrl.sv
// Command decode, bounds check and scan position registers.
// Uses fspg_pkg; feeds one work word per accepted command to fspg_pixel.
module fspg_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [fspg_pkg::POS_W-1:0]     x_pos,
    input  logic [fspg_pkg::POS_W-1:0]     y_pos,
    input  logic [fspg_pkg::SIZE_W-1:0]    size_a,
    input  logic [fspg_pkg::SIZE_W-1:0]    size_b,
    input  logic [fspg_pkg::COLOR_W-1:0]   fill_color,
    input  logic [fspg_pkg::RES_W-1:0]     hr,
    input  logic [fspg_pkg::RES_W-1:0]     vr,
    output logic                           s1_valid,
    input  logic                           s1_ready,
    output fspg_pkg::pix_work_t            s1_work
);
    import fspg_pkg::*;

    localparam int SUM_W = SIZE_W + 1;
    localparam int ASQ_W = 2 * SIZE_W;

    mode_t              mode_reg, mode_next;
    logic [RES_W-1:0]   row_reg, row_next;
    logic [RES_W-1:0]   col_reg, col_next;
    logic [RES_W-1:0]   left_reg, left_next;
    logic [RES_W-1:0]   right_reg, right_next;
    logic [RES_W-1:0]   bottom_reg, bottom_next;
    logic [POS_W-1:0]   ccol_reg, ccol_next;
    logic [POS_W-1:0]   crow_reg, crow_next;
    logic [ADDR_W-1:0]  rsq_reg, rsq_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               s1_valid_reg;
    pix_work_t          work_reg, work_next;

    logic               accept;
    logic [SUM_W-1:0]   sum_xa, sum_yb, sum_ya;
    logic [ASQ_W-1:0]   a_sq;
    logic               bad, empty, lst;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;
    assign s1_valid = s1_valid_reg;
    assign s1_work  = work_reg;

    assign sum_xa = SUM_W'(x_pos) + SUM_W'(size_a);
    assign sum_yb = SUM_W'(y_pos) + SUM_W'(size_b);
    assign sum_ya = SUM_W'(y_pos) + SUM_W'(size_a);
    assign a_sq   = ASQ_W'(size_a) * ASQ_W'(size_a);
    assign lst    = (col_reg == right_reg) && (row_reg == bottom_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        ccol_next   = ccol_reg;
        crow_next   = crow_reg;
        rsq_next    = rsq_reg;
        color_next  = color_reg;
        bad         = 1'b0;
        empty       = 1'b0;

        work_next            = '0;
        work_next.status     = ST_OK;
        work_next.row        = row_reg;
        work_next.col        = col_reg;
        work_next.centre_col = ccol_reg;
        work_next.centre_row = crow_reg;
        work_next.radius_sq  = rsq_reg;
        work_next.color      = color_reg;

        case (op_t'(opcode))
            OP_RECT:
            begin
                mode_next = MODE_IDLE;
                bad   = (sum_xa > SUM_W'(hr)) || (sum_yb > SUM_W'(vr));
                empty = (size_a == '0) || (size_b == '0);
                if (bad)
                begin
                    work_next.status = ST_BAD;
                end
                else if (!empty)
                begin
                    color_next  = fill_color;
                    left_next   = RES_W'(x_pos);
                    col_next    = RES_W'(x_pos);
                    right_next  = RES_W'(sum_xa - SUM_W'(1));
                    row_next    = RES_W'(y_pos);
                    bottom_next = RES_W'(sum_yb - SUM_W'(1));
                    mode_next   = MODE_RECT;
                end
            end
            OP_CIRC:
            begin
                mode_next = MODE_IDLE;
                bad   = (SIZE_W'(x_pos) < size_a) || (sum_xa > SUM_W'(hr)) ||
                        (SIZE_W'(y_pos) < size_a) || (sum_ya > SUM_W'(vr));
                empty = (size_a == '0);
                if (bad)
                begin
                    work_next.status = ST_BAD;
                end
                else if (!empty)
                begin
                    color_next  = fill_color;
                    ccol_next   = x_pos;
                    crow_next   = y_pos;
                    rsq_next    = a_sq[ADDR_W-1:0];
                    left_next   = RES_W'(SUM_W'(x_pos) - SUM_W'(size_a));
                    col_next    = RES_W'(SUM_W'(x_pos) - SUM_W'(size_a));
                    right_next  = RES_W'(sum_xa - SUM_W'(1));
                    row_next    = RES_W'(SUM_W'(y_pos) - SUM_W'(size_a));
                    bottom_next = RES_W'(sum_ya - SUM_W'(1));
                    mode_next   = MODE_CIRC;
                end
            end
            OP_STEP:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    work_next.status = ST_IDLE;
                end
                else
                begin
                    work_next.draw = 1'b1;
                    work_next.circ = (mode_reg == MODE_CIRC);
                    work_next.lst  = lst;
                    if (lst)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (col_reg == right_reg)
                    begin
                        col_next = left_reg;
                        row_next = row_reg + RES_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + RES_W'(1);
                    end
                end
            end
            default:
            begin
                work_next.status = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            bottom_reg   <= '0;
            ccol_reg     <= '0;
            crow_reg     <= '0;
            rsq_reg      <= '0;
            color_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                row_reg    <= row_next;
                col_reg    <= col_next;
                left_reg   <= left_next;
                right_reg  <= right_next;
                bottom_reg <= bottom_next;
                ccol_reg   <= ccol_next;
                crow_reg   <= crow_next;
                rsq_reg    <= rsq_next;
                color_reg  <= color_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// File: rtl/fspg_pixel.sv
// Pixel datapath: squares and row product, then inside test and address add.
// Uses fspg_pkg; takes work words from fspg_ctrl and drives the result word.
module fspg_pixel (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s1_valid,
    output logic                           s1_ready,
    input  fspg_pkg::pix_work_t            s1_work,
    input  logic [fspg_pkg::RES_W-1:0]     hr,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic                           write_valid,
    output logic [fspg_pkg::ADDR_W-1:0]    write_address,
    output logic [7:0]                     red,
    output logic [7:0]                     green,
    output logic [7:0]                     blue,
    output logic                           last
);
    import fspg_pkg::*;

    logic                      s2_valid_reg;
    pix_work_t                 s2_work_reg;
    logic [SQ_W-1:0]           dx_sq_reg, dy_sq_reg;
    logic [PROD_W-1:0]         prod_reg;

    logic                      out_valid_reg;
    status_t                   status_reg;
    logic                      wv_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic                      last_reg;

    logic                      en3;
    logic signed [DIFF_W-1:0]  dx, dy;
    logic signed [SQ_W-1:0]    dx_sq, dy_sq;
    logic [PROD_W-1:0]         prod;
    logic [SQ_W:0]             d2;
    logic [PROD_W:0]           addr_sum;
    logic                      wr;

    assign en3      = !out_valid_reg || out_ready;
    assign s1_ready = !s2_valid_reg || en3;

    assign dx    = $signed({1'b0, s1_work.col}) -
                   $signed({{(DIFF_W-POS_W){1'b0}}, s1_work.centre_col});
    assign dy    = $signed({1'b0, s1_work.row}) -
                   $signed({{(DIFF_W-POS_W){1'b0}}, s1_work.centre_row});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign prod  = PROD_W'(s1_work.row) * PROD_W'(hr);

    assign d2       = (SQ_W+1)'(dx_sq_reg) + (SQ_W+1)'(dy_sq_reg);
    assign addr_sum = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(s2_work_reg.col);
    assign wr       = s2_work_reg.draw &&
                      (!s2_work_reg.circ || (d2 <= (SQ_W+1)'(s2_work_reg.radius_sq)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (en3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid)
        begin
            s2_work_reg <= s1_work;
            dx_sq_reg   <= dx_sq;
            dy_sq_reg   <= dy_sq;
            prod_reg    <= prod;
        end
        if (en3 && s2_valid_reg)
        begin
            status_reg <= s2_work_reg.status;
            wv_reg     <= wr;
            addr_reg   <= wr ? addr_sum[ADDR_W-1:0] : '0;
            color_reg  <= wr ? s2_work_reg.color : '0;
            last_reg   <= s2_work_reg.lst;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign write_valid   = wv_reg;
    assign write_address = addr_reg;
    assign red           = color_reg[23:16];
    assign green         = color_reg[15:8];
    assign blue          = color_reg[7:0];
    assign last          = last_reg;

endmodule

// File: rtl/filled_shape_pixel_generator.sv
// Top level of the filled rectangle and circle fill engine.
// Holds the resolution registers; instantiates fspg_ctrl and fspg_pixel.
//
// The engine takes one command word per clock while in_ready is high and
// returns one result word per command, in order. Start commands check the
// shape against h_res and v_res (values above 4096 count as 4096) and arm a
// scan; each step command then visits the next pixel of the bounding box.
// The scan position register updates in the accepting cycle, the two squares
// and the row times stride product sit in the second stage, and the inside
// test and address add fill the result register. Write h_res and v_res only
// while no command is in flight.
module filled_shape_pixel_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [fspg_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic [fspg_pkg::POS_W-1:0]     x_pos,
    input  logic [fspg_pkg::POS_W-1:0]     y_pos,
    input  logic [fspg_pkg::SIZE_W-1:0]    size_a,
    input  logic [fspg_pkg::SIZE_W-1:0]    size_b,
    input  logic [fspg_pkg::COLOR_W-1:0]   fill_color,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic                           write_valid,
    output logic [fspg_pkg::ADDR_W-1:0]    write_address,
    output logic [7:0]                     red,
    output logic [7:0]                     green,
    output logic [7:0]                     blue,
    output logic                           last
);
    import fspg_pkg::*;

    logic [CFG_W-1:0] h_res_reg, v_res_reg;
    logic [RES_W-1:0] hr, vr;
    logic             s1_valid, s1_ready;
    pix_work_t        s1_work;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_res_reg <= CFG_W'(640);
            v_res_reg <= CFG_W'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_H_RES: h_res_reg <= cfg_data;
                CFG_V_RES: v_res_reg <= cfg_data;
                default:   h_res_reg <= h_res_reg;
            endcase
        end
    end

    // clamp to the largest supported resolution
    assign hr = (h_res_reg > CFG_W'(MAX_RES)) ? RES_W'(MAX_RES) : RES_W'(h_res_reg);
    assign vr = (v_res_reg > CFG_W'(MAX_RES)) ? RES_W'(MAX_RES) : RES_W'(v_res_reg);

    fspg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .size_a     (size_a),
        .size_b     (size_b),
        .fill_color (fill_color),
        .hr         (hr),
        .vr         (vr),
        .s1_valid   (s1_valid),
        .s1_ready   (s1_ready),
        .s1_work    (s1_work)
    );

    fspg_pixel u_pixel (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s1_ready      (s1_ready),
        .s1_work       (s1_work),
        .hr            (hr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .write_valid   (write_valid),
        .write_address (write_address),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .last          (last)
    );

endmodule

// File: rtl/fspg_checker.sv
// Port-level checks of the fill engine result channel, bound to the top level.
// Uses fspg_pkg and filled_shape_pixel_generator_macros.svh.
`include "filled_shape_pixel_generator_macros.svh"

module fspg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic        write_valid,
    input logic [23:0] write_address,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic        last
);
    import fspg_pkg::*;

    `FSPG_ASSERT_NOW(a_write_ok, out_valid && write_valid, status == ST_OK)
    `FSPG_ASSERT_NOW(a_nowrite_zero, out_valid && !write_valid,
        write_address == 24'd0 && red == 8'd0 && green == 8'd0 && blue == 8'd0)
    `FSPG_ASSERT_NOW(a_last_ok, out_valid && last, status == ST_OK)
    `FSPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(write_address) && $stable(status))

endmodule

bind filled_shape_pixel_generator fspg_checker u_fspg_checker (.*);
